>>> rtl/eblz_pkg.sv
// shared types and constants for the escape-byte lz decoder
package eblz_pkg;
	localparam int HistDepthDef = 256;
	localparam int BytesPerResDef = 8;
	localparam int ByteW = 8;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_DIST  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_COPY = 2'd1,
		ST_EMIT = 2'd2
	} ctl_state_t;

	// one history write request from the control to the memory
	typedef struct packed {
		logic       we;
		logic [7:0] wdata;
	} hist_wr_t;
endpackage

>>> rtl/eblz_hist_mem.sv
// history memory with one write and one registered read port
module eblz_hist_mem #(
	parameter int DEPTH = eblz_pkg::HistDepthDef,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import eblz_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/escape_byte_lz_decoder.sv
// escape-byte lz decoder top level: parser, copy sequencer, packer and history memory
// a literal byte's result is registered in the cycle after its transfer; one input per cycle while results are taken
// a match is copied from the length transfer on: a read state and a
//   write-back state per copied byte through the registered read port
// input tready is low while a match is copied or a result waits to be taken
// arst_n clears parser, pointers, counts and the escape code; history is not cleared
module escape_byte_lz_decoder #(
	parameter int HISTORY_DEPTH = eblz_pkg::HistDepthDef,
	parameter int BYTES_PER_RESULT = eblz_pkg::BytesPerResDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tuser,   // stream_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_bytes[63:0], out_count[67:64], zero pad
	output logic        m_tlast,   // out_last
	output logic        m_tuser    // out_error
);
	import eblz_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = AW + 1;
	localparam int FW = $clog2(BYTES_PER_RESULT + 1);

	logic [7:0]    esc_q;
	phase_t        phase_q;
	logic [7:0]    dist_q;
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] prod_q;
	ctl_state_t    st_q, st_d;
	logic [7:0]    rem_q;
	logic [63:0]   acc_q;
	logic [FW-1:0] fill_q;
	logic          rd_s1;
	logic          out_v_q, out_last_q, out_err_q;
	logic [63:0]   out_bytes_q;
	logic [3:0]    out_cnt_q;

	hist_wr_t      wr;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic          acc_in;
	logic [7:0]    b;
	phase_t        ph;
	logic [CW-1:0] prod_in;
	logic          bad;
	logic [FW-1:0] fill_nx;
	logic [63:0]   acc_nx;
	logic          out_free;
	logic          emit_flush;
	logic          out_set;

	eblz_hist_mem #(.DEPTH(HISTORY_DEPTH)) u_mem (
		.clk(clk), .we(wr.we), .waddr(waddr), .wdata(wr.wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign out_free = !out_v_q || m_tready;
	assign s_tready = (st_q == ST_IDLE) && out_free;
	assign acc_in = s_tvalid && s_tready;
	assign b = s_tdata;
	assign ph = s_tuser ? PH_PLAIN : phase_q;
	assign prod_in = (acc_in && s_tuser) ? '0 : prod_q;
	assign bad = (dist_q == 8'd0) || ({{(CW-8){1'b0}}, dist_q} > prod_in);
	assign waddr = (acc_in && s_tuser) ? '0 : wptr_q;
	assign raddr = wptr_q - AW'(dist_q);
	assign fill_nx = fill_q + 1'b1;
	assign emit_flush = (fill_nx == FW'(BYTES_PER_RESULT)) || (rem_q == 8'd1);
	assign out_set = (acc_in && (wr.we || (ph == PH_DIST && bad))) ||
		(st_q == ST_EMIT && wr.we && emit_flush);

	always_comb begin
		acc_nx = acc_q;
		acc_nx[8*fill_q +: 8] = rdata;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (acc_in && ph == PH_DIST && !bad && b != 8'd0) st_d = ST_COPY;
			ST_COPY: st_d = ST_EMIT;
			ST_EMIT: if (out_free && emit_flush)
					st_d = (rem_q == 8'd1) ? ST_IDLE : ST_COPY;
				else if (!emit_flush)
					st_d = ST_COPY;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr.we = 1'b0;
		wr.wdata = b;
		if (st_q == ST_IDLE && acc_in &&
			((ph == PH_ESC && b == esc_q) || (ph != PH_ESC && ph != PH_DIST && b != esc_q))) begin
			wr.we = 1'b1;
		end else if (st_q == ST_EMIT && (out_free || !emit_flush)) begin
			wr.we = 1'b1;
			wr.wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= '0;
			phase_q <= PH_PLAIN;
			dist_q <= '0;
			wptr_q <= '0;
			prod_q <= '0;
			st_q <= ST_IDLE;
			rem_q <= '0;
			acc_q <= '0;
			fill_q <= '0;
			rd_s1 <= 1'b0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
			out_err_q <= 1'b0;
			out_bytes_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (cfg_we) esc_q <= cfg_wdata;
			st_q <= st_d;
			rd_s1 <= (st_d == ST_EMIT);
			if (out_set) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (acc_in && s_tuser) dist_q <= '0;
			if (wr.we) begin
				wptr_q <= waddr + 1'b1;
				prod_q <= (prod_in == CW'(HISTORY_DEPTH)) ? prod_in : prod_in + 1'b1;
			end else if (acc_in && s_tuser) begin
				wptr_q <= '0;
				prod_q <= '0;
			end
			if (acc_in) begin
				out_last_q <= 1'b1;
				out_err_q <= (ph == PH_DIST) && bad;
				case (ph)
					PH_ESC: begin
						if (b == esc_q) begin
							phase_q <= PH_PLAIN;
							out_bytes_q <= {56'd0, b};
							out_cnt_q <= 4'd1;
						end else begin
							phase_q <= PH_DIST;
							dist_q <= (b >= esc_q) ? b - 8'd1 : b;
						end
					end
					PH_DIST: begin
						phase_q <= PH_PLAIN;
						rem_q <= b;
						fill_q <= '0;
						acc_q <= '0;
						if (bad) begin
							out_bytes_q <= '0;
							out_cnt_q <= '0;
						end
					end
					default: begin
						if (b == esc_q) begin
							phase_q <= PH_ESC;
						end else begin
							phase_q <= PH_PLAIN;
							out_bytes_q <= {56'd0, b};
							out_cnt_q <= 4'd1;
						end
					end
				endcase
			end
			if (st_q == ST_EMIT && wr.we) begin
				rem_q <= rem_q - 8'd1;
				if (emit_flush) begin
					out_bytes_q <= acc_nx;
					out_cnt_q <= 4'(fill_nx);
					out_last_q <= (rem_q == 8'd1);
					out_err_q <= 1'b0;
					acc_q <= '0;
					fill_q <= '0;
				end else begin
					acc_q <= acc_nx;
					fill_q <= fill_nx;
				end
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {4'd0, out_cnt_q, out_bytes_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_err_q;

	a_rd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |-> rd_s1) else $error("emit without memory read");
	a_no_take_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !s_tready) else $error("input taken during copy");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_err_q |-> out_cnt_q == 4'd0 && out_last_q) else $error("bad error result");
	a_prod_sat: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q <= CW'(HISTORY_DEPTH)) else $error("count overflow");
endmodule

>>> sim/escape_byte_lz_decoder_tb.sv
// self-checking testbench for the escape-byte lz decoder: directed and random streams, scored against a behavioral model
module escape_byte_lz_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import eblz_pkg::*;

	localparam int HistDepth = 256;
	localparam int BytesPerRes = 8;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        error;
	} decoded_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// behavioral model state
	logic [7:0]    esc_code;
	phase_t        phase;
	logic [7:0]    held_dist;
	logic [7:0]    hist_mem [HistDepth];
	logic [7:0]    wr_ptr;
	int            produced;
	decoded_word_t expected_words[$];

	int  error_count = 0;
	int  cycle_count = 0;
	bit  sink_stalls = 1'b1;
	bit  src_gaps = 1'b1;
	int  sink_hold = 0;
	bit  long_hold = 1'b0;
	event hold_ev;

	escape_byte_lz_decoder DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic void decoder_reset_model();
		esc_code = '0;
		phase = PH_PLAIN;
		held_dist = '0;
		wr_ptr = '0;
		produced = 0;
		for (int i = 0; i < HistDepth; i++) hist_mem[i] = '0;
	endfunction

	function automatic void emit_word(input logic [63:0] acc, input int fill,
			input logic last, input logic err);
		decoded_word_t w;
		w.bytes = acc;
		w.count = 4'(fill);
		w.last = last;
		w.error = err;
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void store_byte(input logic [7:0] b, inout logic [63:0] acc,
			inout int fill);
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 8'd1;
		if (produced < HistDepth) produced++;
		acc |= 64'(b) << (8 * fill);
		fill++;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic start);
		logic [63:0] acc;
		int fill;
		logic [7:0] src;
		acc = '0;
		fill = 0;
		if (start) begin
			phase = PH_PLAIN;
			held_dist = '0;
			wr_ptr = '0;
			produced = 0;
		end
		if (phase == PH_ESC) begin
			if (b == esc_code) begin
				phase = PH_PLAIN;
				store_byte(b, acc, fill);
				emit_word(acc, fill, 1'b1, 1'b0);
			end else begin
				held_dist = (b >= esc_code) ? b - 8'd1 : b;
				phase = PH_DIST;
			end
		end else if (phase == PH_DIST) begin
			phase = PH_PLAIN;
			if (held_dist == 0 || int'(held_dist) > produced) begin
				emit_word('0, 0, 1'b1, 1'b1);
			end else begin
				for (int i = 0; i < int'(b); i++) begin
					src = wr_ptr - held_dist;
					store_byte(hist_mem[src], acc, fill);
					if (fill >= BytesPerRes || i + 1 == int'(b)) begin
						emit_word(acc, fill, (i + 1 == int'(b)), 1'b0);
						acc = '0;
						fill = 0;
					end
				end
			end
		end else begin
			phase = PH_PLAIN;
			if (b == esc_code) phase = PH_ESC;
			else begin
				store_byte(b, acc, fill);
				emit_word(acc, fill, 1'b1, 1'b0);
			end
		end
	endfunction

	// long receiver hold-off, counted in cycles
	always begin
		@(hold_ev);
		long_hold = 1'b1;
		repeat (200) @(posedge clk);
		long_hold = 1'b0;
	end

	// output side: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (long_hold) m_tready <= 1'b0;
		else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else m_tready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata[63:0], '0);
			end else begin
				decoded_word_t w;
				w = expected_words.pop_front();
				if (m_tdata[63:0] !== w.bytes) report_mismatch("bytes", m_tdata[63:0], w.bytes);
				if (m_tdata[67:64] !== w.count)
					report_mismatch("count", 64'(m_tdata[67:64]), 64'(w.count));
				if (m_tdata[71:68] !== 4'd0) report_mismatch("pad", 64'(m_tdata[71:68]), '0);
				if (m_tlast !== w.last) report_mismatch("last", 64'(m_tlast), 64'(w.last));
				if (m_tuser !== w.error) report_mismatch("error", 64'(m_tuser), 64'(w.error));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b, start);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_escape(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		esc_code = v;
	endtask

	task automatic test_directed(input logic [7:0] e);
		write_escape(e);
		send_byte(8'h00 ^ e ^ 8'h5a, 1'b1);
		send_byte(e == 8'hff ? 8'h00 : 8'hff, 1'b0);
		send_byte(e ^ 8'h01, 1'b0);
		send_byte(e, 1'b0); send_byte(e, 1'b0);                // escaped literal
		send_byte(e, 1'b0); send_byte(e == 8'd1 ? 8'd2 : 8'd1, 1'b0); send_byte(8'd20, 1'b0);
		send_byte(e, 1'b0); send_byte(e == 8'd3 ? 8'd2 : 8'd3, 1'b0); send_byte(8'd0, 1'b0);
		send_byte(e, 1'b0); send_byte(e == 8'd0 ? 8'd1 : 8'd0, 1'b0); send_byte(8'd4, 1'b0);
		send_byte(e, 1'b0); send_byte(e == 8'd200 ? 8'd201 : 8'd200, 1'b0); send_byte(8'd9, 1'b0);
		send_byte(e, 1'b0); send_byte(e == 8'd2 ? 8'd3 : 8'd2, 1'b0); send_byte(8'd255, 1'b0);
		send_byte(e, 1'b0); send_byte(e == 8'd5 ? 8'd6 : 8'd5, 1'b0);
		send_byte(e ^ 8'h80, 1'b1);                           // stream cut mid-match
		wait_drained();
	endtask

	task automatic test_random(input int n_items, input logic [7:0] e);
		int sent;
		logic [7:0] b;
		write_escape(e);
		send_byte(e ^ 8'h33, 1'b1);
		sent = 1;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					b = 8'($urandom);
					send_byte(b == e ? b ^ 8'h10 : b, 1'b0);
					sent++;
				end
				4: begin
					send_byte(e, 1'b0); send_byte(e, 1'b0); sent += 2;
				end
				5, 6, 7: begin
					b = 8'($urandom_range(1, (produced > 1) ? ((produced > 255) ? 255 : produced) : 1));
					if (b >= e) b = (b == 8'hff) ? b : b + 8'd1;
					send_byte(e, 1'b0); send_byte(b == e ? b ^ 8'h01 : b, 1'b0);
					send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24)), 1'b0);
					sent += 3;
				end
				8: begin
					send_byte(8'($urandom), $urandom_range(0, 3) == 0); sent++;
				end
				default: begin
					send_byte(8'($urandom), 1'b1); sent++;
				end
			endcase
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_escape(8'h7e);
		-> hold_ev;
		for (int i = 0; i < 40; i++) send_byte(8'(i), i == 0);
		send_byte(8'h7e, 1'b0); send_byte(8'd4, 1'b0); send_byte(8'd100, 1'b0);
		wait_drained();
	endtask

	initial begin
		decoder_reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// escape code still at reset value here
		send_byte(8'd0, 1'b1); send_byte(8'd0, 1'b0);
		send_byte(8'd9, 1'b0); send_byte(8'd0, 1'b0); send_byte(8'd2, 1'b0); send_byte(8'd3, 1'b0);
		wait_drained();
		test_directed(8'h00);
		test_directed(8'hff);
		test_directed(8'h5c);
		test_backpressure();
		test_random(110, 8'h10);
		test_random(110, 8'($urandom));
		sink_stalls = 1'b0;
		src_gaps = 1'b0;
		test_random(90, 8'hc3);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
